/* sv/dpcs_pkg.sv */
// Shared types and constants for the dual PID controller with cross straightening.
// Used by dpcs_lane, dpcs_merge and the top level; depends on nothing else.
package dpcs_pkg;

    // Default sample width and gain fraction bits
    localparam int SAMPLE_BITS_DEF    = 12;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Fixed register widths
    localparam int GAIN_W   = 12;
    localparam int OFFSET_W = 13;
    localparam int LIMIT_W  = 12;
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 3;
    localparam int DRIVE_W  = 8;
    localparam int DRIVE_MAX = 127;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [IDX_W-1:0] REG_STRAIGHT_GAIN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_STRAIGHT_INV   = 3'd4;
    localparam logic [IDX_W-1:0] REG_SIDE_OFFSET    = 3'd5;
    localparam logic [IDX_W-1:0] REG_ERROR_WINDOW   = 3'd6;
    localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd7;

    // PID settings shared by both lanes
    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LIMIT_W-1:0] error_window;
        logic [LIMIT_W-1:0] integral_limit;
    } pid_cfg_t;

    // Straightening settings for the merge stage
    typedef struct packed {
        logic [GAIN_W-1:0]          straighten_gain;
        logic [GAIN_W-1:0]          straighten_inverse;
        logic signed [OFFSET_W-1:0] side_offset;
    } straight_cfg_t;

endpackage

/* sv/dpcs_lane.sv */
// One PID lane: error, windowed and clamped accumulator, then three gain
// multiplies through one shared multiplier. Depends on dpcs_pkg.
module dpcs_lane
    import dpcs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CUR_W       = SAMPLE_BITS + 17
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [SAMPLE_BITS-1:0]  target,
    input  logic [SAMPLE_BITS-1:0]  pot,
    input  pid_cfg_t                cfg,
    output logic                    done,
    output logic signed [CUR_W-1:0] cur
);

    localparam int ERR_W  = SAMPLE_BITS + 1;
    localparam int ACC_W  = LIMIT_W + 1;
    localparam int DIFF_W = SAMPLE_BITS + 2;
    localparam int SUM_W  = ((ERR_W > ACC_W) ? ERR_W : ACC_W) + 1;
    localparam int CMP_W  = (ERR_W > LIMIT_W) ? ERR_W : LIMIT_W;
    localparam int OPD_W  = (DIFF_W > ACC_W) ? DIFF_W : ACC_W;
    localparam int PROD_W = OPD_W + GAIN_W + 1;

    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         mag;
    logic                     in_win;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  lim_s;
    logic signed [SUM_W-1:0]  clamped;

    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  prev_reg;
    logic signed [ACC_W-1:0]  accum_reg, accum_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic                     busy_reg;
    logic [1:0]               step_reg;
    logic                     done_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [CUR_W-1:0]  cur_reg;
    logic [GAIN_W-1:0]        gain_sel;
    logic signed [OPD_W-1:0]  opd_sel;

    // Error, magnitude and window test
    assign err    = $signed({1'b0, target}) - $signed({1'b0, pot});
    assign mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign in_win = (err != '0) && (CMP_W'(mag) < CMP_W'(cfg.error_window));

    // Accumulate and clamp to the limit
    assign sum   = SUM_W'(accum_reg) + SUM_W'(err);
    assign lim_s = $signed({{(SUM_W-LIMIT_W){1'b0}}, cfg.integral_limit});
    always_comb begin
        if (sum > lim_s) begin
            clamped = lim_s;
        end else if (sum < -lim_s) begin
            clamped = -lim_s;
        end else begin
            clamped = sum;
        end
        accum_next = in_win ? ACC_W'(clamped) : '0;
    end

    // Select gain and operand for the shared multiplier
    always_comb begin
        case (step_reg)
            2'd0: begin
                gain_sel = cfg.prop_gain;
                opd_sel  = OPD_W'(err_reg);
            end
            2'd1: begin
                gain_sel = cfg.integ_gain;
                opd_sel  = OPD_W'(accum_reg);
            end
            default: begin
                gain_sel = cfg.deriv_gain;
                opd_sel  = OPD_W'(diff_reg);
            end
        endcase
        prod_next = PROD_W'($signed({1'b0, gain_sel})) * PROD_W'(opd_sel);
    end

    // Sequence: load state, then three multiplies, each product summed in the cycle after it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
            prev_reg  <= '0;
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                accum_reg <= accum_next;
                prev_reg  <= err;
                busy_reg  <= 1'b1;
                step_reg  <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (start) begin
            err_reg  <= err;
            diff_reg <= DIFF_W'(err) - DIFF_W'(prev_reg);
        end
        if (busy_reg) begin
            prod_reg <= prod_next;
            if (step_reg == 2'd1) begin
                cur_reg <= CUR_W'(prod_reg);
            end else if (step_reg != 2'd0) begin
                cur_reg <= cur_reg + CUR_W'(prod_reg);
            end
        end
    end

    assign done = done_reg;
    assign cur  = cur_reg;

endmodule

/* sv/dpcs_merge.sv */
// Merge stage: compares the two samples, scales each lane by the straightening
// factor, truncates toward zero and saturates. Depends on dpcs_pkg.
module dpcs_merge
    import dpcs_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int CUR_W          = SAMPLE_BITS + 17
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [CUR_W-1:0]   cur_left,
    input  logic signed [CUR_W-1:0]   cur_right,
    input  logic [SAMPLE_BITS-1:0]    pot_left,
    input  logic [SAMPLE_BITS-1:0]    pot_right,
    input  straight_cfg_t             cfg,
    output logic                      done,
    output logic signed [DRIVE_W-1:0] drive_left,
    output logic signed [DRIVE_W-1:0] drive_right
);

    localparam int FACT_W = (GAIN_W > GAIN_FRAC_BITS + 1) ? GAIN_W : GAIN_FRAC_BITS + 1;
    localparam int FULL_W = CUR_W + FACT_W + 1;
    localparam int SIDE_W = ((SAMPLE_BITS + 1 > OFFSET_W) ? SAMPLE_BITS + 1 : OFFSET_W) + 1;
    localparam logic [FACT_W-1:0] ONE  = FACT_W'(1) << GAIN_FRAC_BITS;
    localparam logic [FULL_W-1:0] BIAS = (FULL_W'(1) << (2 * GAIN_FRAC_BITS)) - FULL_W'(1);

    logic signed [SIDE_W-1:0] side_l;
    logic signed [SIDE_W-1:0] side_r;
    logic [FACT_W-1:0]        fact_l, fact_r;
    logic signed [FULL_W-1:0] prod_l_reg, prod_r_reg;
    logic                     scaled_reg;
    logic                     done_reg;
    logic signed [DRIVE_W-1:0] drive_l_reg, drive_r_reg;

    // Pick factors from the side comparison
    assign side_l = SIDE_W'($signed({1'b0, pot_left})) - SIDE_W'(cfg.side_offset);
    assign side_r = SIDE_W'($signed({1'b0, pot_right}));
    always_comb begin
        if (side_r > side_l) begin
            fact_r = FACT_W'(cfg.straighten_inverse);
            fact_l = FACT_W'(cfg.straighten_gain);
        end else if (side_r < side_l) begin
            fact_r = FACT_W'(cfg.straighten_gain);
            fact_l = FACT_W'(cfg.straighten_inverse);
        end else begin
            fact_r = ONE;
            fact_l = ONE;
        end
    end

    // Truncate toward zero, then saturate
    function automatic logic signed [DRIVE_W-1:0] finish(input logic signed [FULL_W-1:0] p);
        logic signed [FULL_W-1:0] q;
        begin
            q = (p + (p[FULL_W-1] ? $signed(BIAS) : $signed(FULL_W'(0)))) >>> (2 * GAIN_FRAC_BITS);
            if (q > $signed(FULL_W'(DRIVE_MAX))) begin
                finish = DRIVE_W'(DRIVE_MAX);
            end else if (q < -$signed(FULL_W'(DRIVE_MAX))) begin
                finish = -DRIVE_W'(DRIVE_MAX);
            end else begin
                finish = DRIVE_W'(q);
            end
        end
    endfunction

    // Control: scale stage then finish stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scaled_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            scaled_reg <= start;
            done_reg   <= scaled_reg;
        end
    end

    // Datapath: one multiplier per lane, then truncation toward zero and clamp
    always_ff @(posedge aclk) begin
        if (start) begin
            prod_l_reg <= FULL_W'(cur_left) * FULL_W'($signed({1'b0, fact_l}));
            prod_r_reg <= FULL_W'(cur_right) * FULL_W'($signed({1'b0, fact_r}));
        end
        if (scaled_reg) begin
            drive_l_reg <= finish(prod_l_reg);
            drive_r_reg <= finish(prod_r_reg);
        end
    end

    assign done        = done_reg;
    assign drive_left  = drive_l_reg;
    assign drive_right = drive_r_reg;

endmodule

/* sv/dual_pid_with_cross_straightening_unit.sv */
// Top level of the dual PID controller with cross straightening.
// Instantiates two dpcs_lane copies and dpcs_merge; depends on dpcs_pkg.
//
// Usage:
//   s_ channel: one word per control tick carrying pot_left, pot_right,
//   target_left and target_right. m_ channel: one word per tick carrying
//   drive_left and drive_right. cfg_we/cfg_index/cfg_wdata write the eight
//   settings registers; write them only while no tick is in flight.
// Data path and pacing:
//   A word accepted on s_ goes through both lanes, then the merge stage's
//   scale and finish stages, then the output register on m_tdata. Each lane
//   runs its three gain products through one shared multiplier. The next
//   word is taken only after the last result has moved to the output register.
// Reset:
//   aresetn (synchronous, active low) restores the default settings and
//   clears both accumulators and previous errors; no result is pending.
// Stall:
//   A finished result waits in the output register while m_tready is low;
//   a following result waits in the merge stage, and s_tready stays low until
//   it has moved into the output register.
module dual_pid_with_cross_straightening_unit
    import dpcs_pkg::*;
#(
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // pot_left, pot_right, target_left, target_right (lowest bits first)
    input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // drive_left, drive_right (lowest bits first)
    output logic [2*DRIVE_W-1:0]                 m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_we,
    input  logic [IDX_W-1:0]                     cfg_index,
    input  logic [CFG_W-1:0]                     cfg_wdata
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CUR_W = SB + 2 + GAIN_W + 1 + 2 + ((LIMIT_W + 1 > SB + 2) ? LIMIT_W - SB - 1 : 0);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LANE  = 2'd1;
    localparam logic [1:0] ST_MERGE = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]  state_reg, state_next;
    pid_cfg_t      pid_cfg_reg;
    straight_cfg_t str_cfg_reg;
    logic [SB-1:0] pot_l_reg, pot_r_reg;
    logic          accept;
    logic          lane_done_l, lane_done_r;
    logic signed [CUR_W-1:0] cur_l, cur_r;
    logic          merge_done;
    logic signed [DRIVE_W-1:0] drv_l, drv_r;
    logic [2*DRIVE_W-1:0] out_data_reg;
    logic          out_valid_reg;
    logic          out_free;
    logic          out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Settings registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pid_cfg_reg.prop_gain          <= GAIN_W'(333);
            pid_cfg_reg.integ_gain         <= GAIN_W'(26);
            pid_cfg_reg.deriv_gain         <= GAIN_W'(51);
            pid_cfg_reg.error_window       <= LIMIT_W'(1000);
            pid_cfg_reg.integral_limit     <= LIMIT_W'(500);
            str_cfg_reg.straighten_gain    <= GAIN_W'(256);
            str_cfg_reg.straighten_inverse <= GAIN_W'(256);
            str_cfg_reg.side_offset        <= OFFSET_W'(200);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROP_GAIN:      pid_cfg_reg.prop_gain <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:     pid_cfg_reg.integ_gain <= cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN:     pid_cfg_reg.deriv_gain <= cfg_wdata[GAIN_W-1:0];
                REG_STRAIGHT_GAIN:  str_cfg_reg.straighten_gain <= cfg_wdata[GAIN_W-1:0];
                REG_STRAIGHT_INV:   str_cfg_reg.straighten_inverse <= cfg_wdata[GAIN_W-1:0];
                REG_SIDE_OFFSET:    str_cfg_reg.side_offset <= $signed(cfg_wdata[OFFSET_W-1:0]);
                REG_ERROR_WINDOW:   pid_cfg_reg.error_window <= cfg_wdata[LIMIT_W-1:0];
                REG_INTEGRAL_LIMIT: pid_cfg_reg.integral_limit <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the samples for the side comparison
    always_ff @(posedge aclk) begin
        if (accept) begin
            pot_l_reg <= s_tdata[SB-1:0];
            pot_r_reg <= s_tdata[2*SB-1:SB];
        end
    end

    dpcs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CUR_W       (CUR_W)
    ) u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .target  (s_tdata[3*SB-1:2*SB]),
        .pot     (s_tdata[SB-1:0]),
        .cfg     (pid_cfg_reg),
        .done    (lane_done_l),
        .cur     (cur_l)
    );

    dpcs_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CUR_W       (CUR_W)
    ) u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .target  (s_tdata[4*SB-1:3*SB]),
        .pot     (s_tdata[2*SB-1:SB]),
        .cfg     (pid_cfg_reg),
        .done    (lane_done_r),
        .cur     (cur_r)
    );

    dpcs_merge #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .CUR_W          (CUR_W)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (state_reg == ST_LANE && lane_done_l && lane_done_r),
        .cur_left    (cur_l),
        .cur_right   (cur_r),
        .pot_left    (pot_l_reg),
        .pot_right   (pot_r_reg),
        .cfg         (str_cfg_reg),
        .done        (merge_done),
        .drive_left  (drv_l),
        .drive_right (drv_r)
    );

    // Sequence one tick through lanes, merge and output
    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_LANE;
            end
            ST_LANE: begin
                if (lane_done_l && lane_done_r) state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (merge_done) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {drv_r, drv_l};
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

endmodule
